[rtl/sha1_stream_hasher_top_assert.svh]
// assertion macros for the sha1 stream hasher
// expects clk_i and rst_ni in the scope of each use
`ifndef SHA1_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA1_STREAM_HASHER_TOP_ASSERT_SVH

// cond must never hold at a clock edge
`define SHA1SH_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// cons must hold in the same cycle as ante
`define SHA1SH_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define SHA1SH_IMPLIES_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sha1sh_pkg.sv]
// shared types and constants of the sha1 stream hasher
// no dependencies
package sha1sh_pkg;

  localparam int unsigned BlockBits  = 512;
  localparam int unsigned DigestBits = 160;

  localparam logic [2:0] DigestWords = 3'd5;
  localparam logic [7:0] PadByte     = 8'h80;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  typedef enum logic {
    KIND_ABSORB = 1'b0,
    KIND_FINISH = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

[rtl/sha1sh_front.sv]
// front end: accepts stream transactions, classifies them, two-entry queue
// depends on sha1sh_pkg
module sha1sh_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              op_i,
  input  logic [7:0]        data_i,
  output logic              item_valid_o,
  output sha1sh_pkg::item_t item_o,
  input  logic              item_pop_i
);
  import sha1sh_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  item_kind_e kind;

  always_comb begin
    unique case (op_i)
      1'b0:    kind = KIND_ABSORB;
      default: kind = KIND_FINISH;
    endcase
  end

  assign s_ready_o    = (count_q != 2'd2);
  assign push         = s_valid_i & s_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (item_pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push && !item_pop_i) count_q <= count_q + 2'd1;
      else if (!push && item_pop_i) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{kind: kind, data: data_i};
    end
  end

endmodule

[rtl/sha1sh_core.sv]
// sha1 compression core: one round per cycle over a 16-word schedule window
// depends on sha1sh_pkg
module sha1sh_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha1sh_pkg::core_ctrl_t ctrl_i,
  input  logic [511:0]           block_i,
  output sha1sh_pkg::core_stat_t stat_o,
  output logic [159:0]           cv_o
);
  import sha1sh_pkg::*;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } core_state_e;

  core_state_e state_q;
  logic [6:0]  round_q;
  logic [31:0] h_q [5];
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] fn, kc, t_sum, w_mix, w_new;
  logic        load;

  always_comb begin
    priority if (round_q < 7'd20) begin
      fn = (b_q & c_q) | (~b_q & d_q);
      kc = 32'h5A827999;
    end else if (round_q < 7'd40) begin
      fn = b_q ^ c_q ^ d_q;
      kc = 32'h6ED9EBA1;
    end else if (round_q < 7'd60) begin
      fn = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      kc = 32'h8F1BBCDC;
    end else begin
      fn = b_q ^ c_q ^ d_q;
      kc = 32'hCA62C1D6;
    end
  end

  assign t_sum = {a_q[26:0], a_q[31:27]} + fn + e_q + kc + w_q[0];
  assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign load  = ctrl_i.start && (state_q == CORE_IDLE) && !ctrl_i.init;

  assign stat_o.busy = (state_q != CORE_IDLE);
  assign stat_o.done = (state_q == CORE_ADD);
  assign cv_o        = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      round_q <= 7'd0;
      h_q[0]  <= Iv0;
      h_q[1]  <= Iv1;
      h_q[2]  <= Iv2;
      h_q[3]  <= Iv3;
      h_q[4]  <= Iv4;
    end else begin
      unique case (state_q)
        CORE_IDLE: begin
          if (ctrl_i.init) begin
            h_q[0] <= Iv0;
            h_q[1] <= Iv1;
            h_q[2] <= Iv2;
            h_q[3] <= Iv3;
            h_q[4] <= Iv4;
          end else if (ctrl_i.start) begin
            state_q <= CORE_ROUND;
            round_q <= 7'd0;
          end
        end
        CORE_ROUND: begin
          round_q <= round_q + 7'd1;
          if (round_q == 7'd79) state_q <= CORE_ADD;
        end
        CORE_ADD: begin
          h_q[0]  <= h_q[0] + a_q;
          h_q[1]  <= h_q[1] + b_q;
          h_q[2]  <= h_q[2] + c_q;
          h_q[3]  <= h_q[3] + d_q;
          h_q[4]  <= h_q[4] + e_q;
          state_q <= CORE_IDLE;
        end
        default: state_q <= CORE_IDLE;
      endcase
    end
  end

  // block word 0 sits in the top bits of the buffer
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[(15 - i) * 32 +: 32];
      end
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (state_q == CORE_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
      e_q     <= d_q;
      d_q     <= c_q;
      c_q     <= {b_q[1:0], b_q[31:2]};
      b_q     <= a_q;
      a_q     <= t_sum;
    end
  end

endmodule

[rtl/sha1sh_back.sv]
// back end: block buffer, length count, padding sequencer, digest output register
// depends on sha1sh_pkg, drives sha1sh_core through its control struct
module sha1sh_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  sha1sh_pkg::item_t      item_i,
  output logic                   item_pop_o,
  output sha1sh_pkg::core_ctrl_t core_ctrl_o,
  output logic [511:0]           block_o,
  input  sha1sh_pkg::core_stat_t core_stat_i,
  input  logic [159:0]           cv_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [31:0]            out_word_o,
  output logic [2:0]             out_index_o,
  output logic                   out_last_o
);
  import sha1sh_pkg::*;

  typedef enum logic [1:0] {
    BACK_ABSORB,
    BACK_PAD,
    BACK_FINAL
  } back_state_e;

  back_state_e               state_q;
  logic [5:0]                pos_q;
  logic [63:0]               len_q;
  logic                      pending_q, first_q, extra_q;
  logic [2:0]                out_cnt_q;
  logic [BlockBits-1:0]      buf_q;
  logic [DigestBits-1:0]     digest_q;
  logic                      start, absorb_wr, pad_wr, wr_en, final_go, out_fire;
  logic [7:0]                pad_byte, wr_byte;

  assign start      = pending_q & ~core_stat_i.busy;
  assign item_pop_o = (state_q == BACK_ABSORB) & ~pending_q & item_valid_i;
  assign absorb_wr  = item_pop_o & (item_i.kind == KIND_ABSORB);
  assign pad_wr     = (state_q == BACK_PAD) & ~pending_q;
  assign wr_en      = absorb_wr | pad_wr;
  assign final_go   = (state_q == BACK_FINAL) & ~pending_q & ~core_stat_i.busy
                    & (out_cnt_q == 3'd0);
  assign out_fire   = out_valid_o & out_ready_i;

  // length bytes go big-endian into the last eight places of the final block
  always_comb begin
    priority if (first_q) pad_byte = PadByte;
    else if (pos_q[5:3] == 3'b111 && !extra_q) pad_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];
    else pad_byte = 8'h00;
  end

  assign wr_byte = pad_wr ? pad_byte : item_i.data;

  assign core_ctrl_o.start = start;
  assign core_ctrl_o.init  = final_go;
  assign block_o           = buf_q;

  assign out_valid_o = (out_cnt_q != 3'd0);
  assign out_word_o  = digest_q[DigestBits-1 -: 32];
  assign out_index_o = DigestWords - out_cnt_q;
  assign out_last_o  = (out_cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BACK_ABSORB;
      pos_q     <= 6'd0;
      len_q     <= 64'd0;
      pending_q <= 1'b0;
      first_q   <= 1'b0;
      extra_q   <= 1'b0;
      out_cnt_q <= 3'd0;
    end else begin
      if (start) pending_q <= 1'b0;
      if (wr_en) begin
        pos_q <= pos_q + 6'd1;
        if (pos_q == 6'd63) pending_q <= 1'b1;
      end
      if (absorb_wr) len_q <= len_q + 64'd8;

      unique case (state_q)
        BACK_ABSORB: begin
          if (item_pop_o && item_i.kind == KIND_FINISH) begin
            state_q <= BACK_PAD;
            first_q <= 1'b1;
          end
        end
        BACK_PAD: begin
          if (pad_wr) begin
            first_q <= 1'b0;
            // marker too late for the length: one more block follows
            if (pos_q == 6'd63) extra_q <= 1'b0;
            else if (first_q && pos_q[5:3] == 3'b111) extra_q <= 1'b1;
            if (pos_q == 6'd63 && !extra_q && !first_q) state_q <= BACK_FINAL;
          end
        end
        BACK_FINAL: begin
          if (final_go) begin
            state_q <= BACK_ABSORB;
            len_q   <= 64'd0;
          end
        end
        default: state_q <= BACK_ABSORB;
      endcase

      if (final_go) out_cnt_q <= DigestWords;
      else if (out_fire) out_cnt_q <= out_cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q <= {buf_q[BlockBits-9:0], wr_byte};
    if (final_go) digest_q <= cv_i;
    else if (out_fire) digest_q <= {digest_q[DigestBits-33:0], 32'h0};
  end

endmodule

[rtl/sha1_stream_hasher_top.sv]
// sha1 stream hasher top: front queue, back end and compression core
// absorb: one byte per cycle unless a full block waits for the busy core; each block
// passes the round core (load, 80 rounds, add) overlapped with filling the next block
// finish: 64 - pos padding bytes, 64 more if under 9 bytes free, compression, 5 words
// reset (rst_ni low, async): empty queue, zero length, initial chaining value
// depends on sha1sh_pkg, sha1sh_front, sha1sh_back, sha1sh_core
`include "sha1_stream_hasher_top_assert.svh"
module sha1_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast_o    // last_word
);
  import sha1sh_pkg::*;

  item_t        item;
  logic         item_valid, item_pop;
  core_ctrl_t   core_ctrl;
  core_stat_t   core_stat;
  logic [511:0] block;
  logic [159:0] cv;
  logic [31:0]  out_word;
  logic [2:0]   out_index;

  sha1sh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .op_i         (s_axis_tuser_i),
    .data_i       (s_axis_tdata_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  sha1sh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .core_ctrl_o  (core_ctrl),
    .block_o      (block),
    .core_stat_i  (core_stat),
    .cv_i         (cv),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_word_o   (out_word),
    .out_index_o  (out_index),
    .out_last_o   (m_axis_tlast_o)
  );

  sha1sh_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (core_ctrl),
    .block_i (block),
    .stat_o  (core_stat),
    .cv_o    (cv)
  );

  assign m_axis_tdata_o = {5'b0, out_index, out_word};

  `SHA1SH_NEVER(a_no_start_when_busy, core_ctrl.start && core_stat.busy, "core started while busy")
  `SHA1SH_IMPLIES_NEXT(a_done_then_idle, core_stat.done, !core_stat.busy, "core busy after done")
  `SHA1SH_IMPLIES(a_last_is_word4, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o[34:32] == 3'd4, "last on wrong word")
  `SHA1SH_IMPLIES(a_pop_needs_item, item_pop, item_valid, "pop from empty queue")

endmodule
